// ----- src/euclidean_feature_transform_unit_assert.svh -----
// assertion macros for the euclidean feature transform unit
// used by the top level only, no other dependencies
`ifndef EUCLIDEAN_FEATURE_TRANSFORM_UNIT_ASSERT_SVH
`define EUCLIDEAN_FEATURE_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication
`define EFTU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eftu check failed");

// next-cycle implication
`define EFTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eftu check failed");

`endif

// ----- src/eftu_pkg.sv -----
// shared types and constants of the euclidean feature transform unit
// no dependencies
package eftu_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int PIX_W          = 8;
  localparam int OUT_COL_W      = 10;
  localparam int OUT_ROW_W      = 8;
  localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RPA_RD,
    ST_RPA_WR,
    ST_RPB_RD,
    ST_RPB_WR,
    ST_CPI_RD,
    ST_CPI_WR,
    ST_CPU_RD,
    ST_CPU_LD,
    ST_CP_SRD,
    ST_CP_MUL,
    ST_CP_CMP,
    ST_CP_DIV,
    ST_CP_PUSH,
    ST_RO_RD,
    ST_RO_WR
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic read_en;
    logic rp_init;
    logic a_rd;
    logic a_wr;
    logic b_rd;
    logic b_wr;
    logic ci_rd;
    logic ci_wr;
    logic u_rd;
    logic u_ld;
    logic seg_rd;
    logic mul;
    logic pop;
    logic empty_set;
    logic div_start;
    logic push_try;
    logic ro_rd;
    logic ro_wr;
  } cmd_t;

  typedef struct packed {
    logic col_zero;
    logic col_last;
    logic row_last;
    logic u_last;
    logic u_zero;
    logic h_one;
    logic pop;
    logic top_zero;
    logic div_done;
  } sts_t;

endpackage

// ----- src/eftu_div.sv -----
// signed by unsigned divider, one quotient bit per cycle, truncates toward zero
// depends on nothing
module eftu_div #(
  parameter int NW   = 30,
  parameter int DENW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DENW-1:0]      den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   mag;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] dnr;
  logic            neg;
  logic [DENW:0]   trial;

  assign trial = {rem, mag[NW-1]};
  assign quo   = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= (num < 0) ? NW'(-num) : NW'(num);
      neg <= num < 0;
      rem <= '0;
      dnr <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dnr}) begin
        rem <= DENW'(trial - {1'b0, dnr});
        mag <= {mag[NW-2:0], 1'b1};
      end else begin
        rem <= DENW'(trial);
        mag <= {mag[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/eftu_ctrl.sv -----
// sequencer of the transform: load and read handshake, row pass, column pass
// depends on eftu_pkg
module eftu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          func,
  input  logic          load_last,
  input  eftu_pkg::sts_t sts,
  output logic          busy,
  output eftu_pkg::cmd_t cmd
);

  eftu_pkg::state_t state, state_next;

  assign busy = state != eftu_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eftu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      eftu_pkg::ST_IDLE: begin
        if (start && func == eftu_pkg::FUNC_LOAD && load_last) begin
          state_next = eftu_pkg::ST_RPA_RD;
        end
      end
      eftu_pkg::ST_RPA_RD: state_next = eftu_pkg::ST_RPA_WR;
      eftu_pkg::ST_RPA_WR: begin
        state_next = sts.col_zero ? eftu_pkg::ST_RPB_RD : eftu_pkg::ST_RPA_RD;
      end
      eftu_pkg::ST_RPB_RD: state_next = eftu_pkg::ST_RPB_WR;
      eftu_pkg::ST_RPB_WR: begin
        if (sts.col_last) begin
          state_next = sts.row_last ? eftu_pkg::ST_CPI_RD : eftu_pkg::ST_RPA_RD;
        end else begin
          state_next = eftu_pkg::ST_RPB_RD;
        end
      end
      eftu_pkg::ST_CPI_RD: state_next = eftu_pkg::ST_CPI_WR;
      eftu_pkg::ST_CPI_WR: begin
        state_next = sts.h_one ? eftu_pkg::ST_RO_RD : eftu_pkg::ST_CPU_RD;
      end
      eftu_pkg::ST_CPU_RD: state_next = eftu_pkg::ST_CPU_LD;
      eftu_pkg::ST_CPU_LD: state_next = eftu_pkg::ST_CP_MUL;
      eftu_pkg::ST_CP_SRD: state_next = eftu_pkg::ST_CP_MUL;
      eftu_pkg::ST_CP_MUL: state_next = eftu_pkg::ST_CP_CMP;
      eftu_pkg::ST_CP_CMP: begin
        if (sts.pop && sts.top_zero) begin
          state_next = sts.u_last ? eftu_pkg::ST_RO_RD : eftu_pkg::ST_CPU_RD;
        end else if (sts.pop) begin
          state_next = eftu_pkg::ST_CP_SRD;
        end else begin
          state_next = eftu_pkg::ST_CP_DIV;
        end
      end
      eftu_pkg::ST_CP_DIV: begin
        if (sts.div_done) begin
          state_next = eftu_pkg::ST_CP_PUSH;
        end
      end
      eftu_pkg::ST_CP_PUSH: begin
        state_next = sts.u_last ? eftu_pkg::ST_RO_RD : eftu_pkg::ST_CPU_RD;
      end
      eftu_pkg::ST_RO_RD: state_next = eftu_pkg::ST_RO_WR;
      eftu_pkg::ST_RO_WR: begin
        if (sts.u_zero) begin
          state_next = sts.col_last ? eftu_pkg::ST_IDLE : eftu_pkg::ST_CPI_RD;
        end else begin
          state_next = eftu_pkg::ST_RO_RD;
        end
      end
      default: state_next = eftu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      eftu_pkg::ST_IDLE: begin
        cmd.load_wr = start && func == eftu_pkg::FUNC_LOAD;
        cmd.read_en = start && func == eftu_pkg::FUNC_READ;
        cmd.rp_init = start && func == eftu_pkg::FUNC_LOAD && load_last;
      end
      eftu_pkg::ST_RPA_RD:  cmd.a_rd = 1'b1;
      eftu_pkg::ST_RPA_WR:  cmd.a_wr = 1'b1;
      eftu_pkg::ST_RPB_RD:  cmd.b_rd = 1'b1;
      eftu_pkg::ST_RPB_WR:  cmd.b_wr = 1'b1;
      eftu_pkg::ST_CPI_RD:  cmd.ci_rd = 1'b1;
      eftu_pkg::ST_CPI_WR:  cmd.ci_wr = 1'b1;
      eftu_pkg::ST_CPU_RD:  cmd.u_rd = 1'b1;
      eftu_pkg::ST_CPU_LD:  cmd.u_ld = 1'b1;
      eftu_pkg::ST_CP_SRD:  cmd.seg_rd = 1'b1;
      eftu_pkg::ST_CP_MUL:  cmd.mul = 1'b1;
      eftu_pkg::ST_CP_CMP: begin
        cmd.empty_set = sts.pop && sts.top_zero;
        cmd.pop       = sts.pop && !sts.top_zero;
        cmd.div_start = !sts.pop;
      end
      eftu_pkg::ST_CP_DIV:  cmd = '0;
      eftu_pkg::ST_CP_PUSH: cmd.push_try = 1'b1;
      eftu_pkg::ST_RO_RD:   cmd.ro_rd = 1'b1;
      eftu_pkg::ST_RO_WR:   cmd.ro_wr = 1'b1;
      default:              cmd = '0;
    endcase
  end

endmodule

// ----- src/eftu_dp.sv -----
// datapath: image, row pass and result memories, segment stack, distance math
// depends on eftu_pkg and eftu_div
module eftu_dp #(
  parameter int MAX_WIDTH  = eftu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = eftu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [eftu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eftu_pkg::CFG_W-1:0]     cfg_data,
  input  logic [eftu_pkg::PIX_W-1:0]     pixel_x,
  input  logic [eftu_pkg::PIX_W-1:0]     pixel_y,
  input  logic                           pixel_set,
  input  eftu_pkg::cmd_t                 cmd,
  output eftu_pkg::sts_t                 sts,
  output logic                           result_valid,
  output logic [eftu_pkg::OUT_COL_W-1:0] nearest_col,
  output logic [eftu_pkg::OUT_ROW_W-1:0] nearest_row
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(NPIX);
  localparam int DW    = $clog2(2 * MAX_WIDTH + MAX_HEIGHT);
  localparam int GW    = DW + 1;
  localparam int SW    = YW + 2;
  localparam int EW    = (GW > SW + 1) ? GW : SW + 1;
  localparam int PW    = 2 * EW;
  localparam int NW    = PW + 2;
  localparam int DENW  = YW + 2;
  localparam int SEG_D = MAX_HEIGHT + 1;

  function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
    pix_addr = AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
  endfunction

  // configuration
  logic [eftu_pkg::CFG_W-1:0] width_reg;
  logic [eftu_pkg::CFG_W-1:0] height_reg;
  logic [CW-1:0]              w_eff;
  logic [HW-1:0]              h_eff;
  logic [XW-1:0]              w_m1;
  logic [YW-1:0]              h_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= eftu_pkg::DIM_RESET;
      height_reg <= eftu_pkg::DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        eftu_pkg::REG_WIDTH:  width_reg  <= cfg_data;
        eftu_pkg::REG_HEIGHT: height_reg <= cfg_data;
        default: width_reg <= width_reg;
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_reg);
    end
    w_m1 = XW'(w_eff - 1'b1);
    h_m1 = YW'(h_eff - 1'b1);
  end

  // counters and working registers
  logic [YW-1:0] row;
  logic [XW-1:0] col;
  logic [YW-1:0] u;
  logic [HW-1:0] top;
  logic [DW-1:0] run;
  logic [DW-1:0] prev;
  logic [DW-1:0] gu;

  // memories
  logic          pix_mem [NPIX];
  logic [DW-1:0] rdl_mem [MAX_WIDTH];
  logic [DW-1:0] row_mem [NPIX];
  logic [YW-1:0] segr_mem [SEG_D];
  logic [DW-1:0] segg_mem [SEG_D];
  logic [SW-1:0] segs_mem [SEG_D];
  logic [DW-1:0] resc_mem [NPIX];
  logic [YW-1:0] resr_mem [NPIX];

  logic          pix_q;
  logic [DW-1:0] rdl_q;
  logic [DW-1:0] row_q;
  logic [YW-1:0] segr_q;
  logic [DW-1:0] segg_q;
  logic [SW-1:0] segs_q;
  logic [DW-1:0] resc_q;
  logic [YW-1:0] resr_q;

  logic          ld_ok;
  logic          rd_ok;
  logic [AW-1:0] io_addr;
  logic [AW-1:0] rc_addr;
  logic [AW-1:0] uc_addr;
  logic [AW-1:0] row_raddr;

  assign ld_ok   = 32'(pixel_x) < 32'(MAX_WIDTH) && 32'(pixel_y) < 32'(MAX_HEIGHT);
  assign rd_ok   = 32'(pixel_x) < 32'(w_eff) && 32'(pixel_y) < 32'(h_eff);
  assign io_addr = pix_addr(YW'(pixel_y), XW'(pixel_x));
  assign rc_addr = pix_addr(row, col);
  assign uc_addr = pix_addr(u, col);
  assign row_raddr = cmd.ci_rd ? pix_addr('0, col) : uc_addr;

  // row pass values
  logic [DW-1:0]        rdl_val;
  logic [DW-1:0]        rp_val;
  logic signed [DW+1:0] c_s;
  logic signed [DW+1:0] prev_s;
  logic signed [DW+1:0] rdl_s;

  always_comb begin
    c_s    = $signed((DW + 2)'(col));
    prev_s = $signed((DW + 2)'(prev));
    rdl_s  = $signed((DW + 2)'(rdl_q));
    if (pix_q) begin
      rdl_val = '0;
    end else if (col == w_m1) begin
      rdl_val = DW'(32'(w_eff) + 32'(h_eff));
    end else begin
      rdl_val = run + 1'b1;
    end
    if (col == '0) begin
      rp_val = rdl_q;
    end else if (c_s - prev_s <= rdl_s) begin
      rp_val = prev;
    end else begin
      rp_val = DW'(col) + rdl_q;
    end
  end

  // column pass distance math
  logic signed [EW-1:0] s_e;
  logic signed [EW-1:0] sr_e;
  logic signed [EW-1:0] u_e;
  logic signed [EW-1:0] c_e;
  logic signed [EW-1:0] gs_e;
  logic signed [EW-1:0] gu_e;
  logic signed [EW-1:0] d_top;
  logic signed [EW-1:0] d_id;
  logic signed [EW-1:0] d_du;
  logic signed [EW-1:0] d_ud;
  logic signed [PW-1:0] sq_top;
  logic signed [PW-1:0] sq_id;
  logic signed [PW-1:0] sq_du;
  logic signed [PW-1:0] sq_ud;
  logic signed [PW-1:0] sq_u;
  logic signed [PW-1:0] sq_ir;
  logic signed [PW:0]   dist_top;
  logic signed [PW:0]   dist_u;
  logic signed [NW-1:0] num;
  logic [DENW-1:0]      den;
  logic signed [NW-1:0] quo;
  logic signed [NW-1:0] cv;
  logic                 div_done;
  logic                 push_ok;

  always_comb begin
    s_e   = EW'($signed(segs_q));
    sr_e  = $signed(EW'(segr_q));
    u_e   = $signed(EW'(u));
    c_e   = $signed(EW'(col));
    gs_e  = $signed(EW'(segg_q));
    gu_e  = $signed(EW'(gu));
    d_top = s_e - sr_e;
    d_id  = c_e - gs_e;
    d_du  = s_e - u_e;
    d_ud  = c_e - gu_e;
    dist_top = (PW + 1)'(sq_top) + (PW + 1)'(sq_id);
    dist_u   = (PW + 1)'(sq_du) + (PW + 1)'(sq_ud);
    num = NW'(sq_u) - NW'(sq_ir) + NW'(sq_ud) - NW'(sq_id);
    den = {(YW + 1)'((YW + 1)'(u) - (YW + 1)'(segr_q)), 1'b0};
    cv  = quo + NW'(1);
    push_ok = cv < $signed(NW'(h_eff)) && 32'(top) < 32'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_top <= d_top * d_top;
      sq_id  <= d_id * d_id;
      sq_du  <= d_du * d_du;
      sq_ud  <= d_ud * d_ud;
      sq_u   <= u_e * u_e;
      sq_ir  <= sr_e * sr_e;
    end
  end

  eftu_div #(
    .NW   (NW),
    .DENW (DENW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (cmd.ci_wr || cmd.empty_set) begin
      top <= '0;
    end else if (cmd.pop) begin
      top <= top - 1'b1;
    end else if (cmd.push_try && push_ok) begin
      top <= top + 1'b1;
    end else if (cmd.ro_wr && u == YW'(segs_q) && $signed(segs_q) >= 0
                 && 32'($signed(segs_q)) == 32'(u) && top != '0) begin
      top <= top - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rp_init) begin
      row <= '0;
      col <= w_m1;
    end else if (cmd.a_wr) begin
      run <= rdl_val;
      if (col != '0) begin
        col <= col - 1'b1;
      end
    end else if (cmd.b_wr) begin
      prev <= rp_val;
      if (col != w_m1) begin
        col <= col + 1'b1;
      end else begin
        row <= row + 1'b1;
        col <= (row == h_m1) ? '0 : w_m1;
      end
    end else if (cmd.ro_wr && u == '0 && col != w_m1) begin
      col <= col + 1'b1;
    end
    if (cmd.ci_wr) begin
      u <= (h_m1 == '0) ? '0 : YW'(1);
    end else if ((cmd.empty_set || cmd.push_try) && u != h_m1) begin
      u <= u + 1'b1;
    end else if (cmd.ro_wr && u != '0) begin
      u <= u - 1'b1;
    end
    if (cmd.u_ld) begin
      gu <= row_q;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.load_wr && ld_ok) begin
      pix_mem[io_addr] <= pixel_set;
    end
    if (cmd.a_rd) begin
      pix_q <= pix_mem[rc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.a_wr) begin
      rdl_mem[col] <= rdl_val;
    end
    if (cmd.b_rd) begin
      rdl_q <= rdl_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.b_wr) begin
      row_mem[rc_addr] <= rp_val;
    end
    if (cmd.ci_rd || cmd.u_rd) begin
      row_q <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ci_wr) begin
      segr_mem[0] <= '0;
      segg_mem[0] <= row_q;
      segs_mem[0] <= '0;
    end else if (cmd.empty_set) begin
      segr_mem[0] <= u;
      segg_mem[0] <= gu;
    end else if (cmd.push_try && push_ok) begin
      segr_mem[HW'(top + 1'b1)] <= u;
      segg_mem[HW'(top + 1'b1)] <= gu;
      segs_mem[HW'(top + 1'b1)] <= SW'(cv);
    end
    if (cmd.u_rd || cmd.seg_rd || cmd.ro_rd) begin
      segr_q <= segr_mem[top];
      segg_q <= segg_mem[top];
      segs_q <= segs_mem[top];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ro_wr) begin
      resc_mem[uc_addr] <= segg_q;
      resr_mem[uc_addr] <= segr_q;
    end
    if (cmd.read_en) begin
      resc_q <= resc_mem[io_addr];
      resr_q <= resr_mem[io_addr];
    end
  end

  // read result strobe
  logic rd_pend;
  logic rd_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.read_en;
    end
    if (cmd.read_en) begin
      rd_in <= rd_ok;
    end
  end

  assign result_valid = rd_pend;
  assign nearest_col  = rd_in ? eftu_pkg::OUT_COL_W'(resc_q) : '0;
  assign nearest_row  = rd_in ? eftu_pkg::OUT_ROW_W'(resr_q) : '0;

  always_comb begin
    sts.col_zero = col == '0;
    sts.col_last = col == w_m1;
    sts.row_last = row == h_m1;
    sts.u_last   = u == h_m1;
    sts.u_zero   = u == '0;
    sts.h_one    = h_m1 == '0;
    sts.pop      = dist_top > dist_u;
    sts.top_zero = top == '0;
    sts.div_done = div_done;
  end

endmodule

// ----- src/euclidean_feature_transform_unit.sv -----
// top level of the euclidean feature transform unit
// depends on eftu_pkg, eftu_ctrl, eftu_dp and the assertion macro header
//
// channel   direction  handshake                       payload
// input     in         start, accepted when busy low   func pixel_x pixel_y pixel_set load_last
// result    out        result_valid, one cycle strobe  nearest_col nearest_row
// config    in         cfg_write, no wait              cfg_index cfg_data
//
// loads and reads may follow back to back while busy is low; a read's result shows in the next cycle
// a load flagged last holds busy through the row pass, then per column a setup,
// an envelope update per row from the second on with each pop and each division
// (24 quotient bits, one a cycle) followed by a push attempt, and a readout of the column
// rst is synchronous; memories hold no reset value, the receiver cannot stall
`include "euclidean_feature_transform_unit_assert.svh"

module euclidean_feature_transform_unit #(
  parameter int MAX_WIDTH  = eftu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = eftu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [eftu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eftu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [eftu_pkg::PIX_W-1:0]     pixel_x,
  input  logic [eftu_pkg::PIX_W-1:0]     pixel_y,
  input  logic                           pixel_set,
  input  logic                           load_last,
  output logic                           result_valid,
  output logic [eftu_pkg::OUT_COL_W-1:0] nearest_col,
  output logic [eftu_pkg::OUT_ROW_W-1:0] nearest_row
);

  eftu_pkg::cmd_t cmd;
  eftu_pkg::sts_t sts;

  eftu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .load_last (load_last),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  eftu_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_set    (pixel_set),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .nearest_col  (nearest_col),
    .nearest_row  (nearest_row)
  );

  `EFTU_ASSERT_NEXT(a_read_gives_result, start && !busy && func, result_valid)
  `EFTU_ASSERT_NOW(a_result_from_read, result_valid, $past(start && !busy && func))
  `EFTU_ASSERT_NOW(a_busy_quiet, busy, !result_valid)
  `EFTU_ASSERT_NEXT(a_last_load_busy, start && !busy && !func && load_last, busy)

endmodule

// ----- dv/tb_euclidean_feature_transform_unit.sv -----
// testbench for euclidean_feature_transform_unit: loads whole binary frames at many sizes,
// reads back the nearest feature pixel at random positions and checks it against a predictor
// depends on eftu_pkg and the block's rtl only
`timescale 1ns / 100ps

import eftu_pkg::*;

typedef struct packed {
  logic [OUT_COL_W-1:0] col;
  logic [OUT_ROW_W-1:0] row;
} nearest_t;

class feature_scoreboard;
  localparam int MW = 256;
  localparam int MH = 256;

  bit             pix_mem [MW*MH];
  int             row_near[MW*MH];
  int             right_run[MW];
  int             env_row [MH+1];
  int             env_start[MH+1];
  int             env_top;
  logic [9:0]     near_col[MW*MH];
  logic [7:0]     near_row[MW*MH];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  nearest_t       nearest_q[$];
  int             errors;
  int             reads;
  int             loads;
  int             frames;

  function new();
    width_reg  = DIM_RESET;
    height_reg = DIM_RESET;
    env_top    = 0;
  endfunction

  function automatic int eff(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic longint dist2(int xr, int ir, int c);
    longint d, r;
    d = longint'(c) - longint'(row_near[ir*MW+c]);
    r = longint'(xr) - longint'(ir);
    return r*r + d*d;
  endfunction

  function automatic int separation(int ir, int ur, int c);
    longint id, ud, num, den;
    if (ur == ir) return 0;
    id  = longint'(c) - longint'(row_near[ir*MW+c]);
    ud  = longint'(c) - longint'(row_near[ur*MW+c]);
    num = longint'(ur)*ur - longint'(ir)*ir + ud*ud - id*id;
    den = 2*(longint'(ur) - longint'(ir));
    return int'(num / den);
  endfunction

  function automatic void transform();
    int w, h, base, prev, cv, sr;
    w = eff(width_reg, MW);
    h = eff(height_reg, MH);
    frames++;
    // row pass
    for (int r = 0; r < h; r++) begin
      base = r*MW;
      right_run[w-1] = pix_mem[base+w-1] ? 0 : w + h;
      for (int c = w-2; c >= 0; c--)
        right_run[c] = pix_mem[base+c] ? 0 : 1 + right_run[c+1];
      row_near[base] = right_run[0];
      for (int c = 1; c < w; c++) begin
        prev = row_near[base+c-1];
        if (c - prev <= right_run[c]) row_near[base+c] = prev;
        else row_near[base+c] = c + right_run[c];
      end
    end
    // column pass on the lower envelope
    for (int c = 0; c < w; c++) begin
      env_top = 0;
      env_row[0] = 0;
      env_start[0] = 0;
      for (int u = 1; u < h; u++) begin
        while (env_top >= 0 &&
               dist2(env_start[env_top], env_row[env_top], c) >
               dist2(env_start[env_top], u, c))
          env_top--;
        if (env_top < 0) begin
          env_top = 0;
          env_row[0] = u;
        end else begin
          cv = 1 + separation(env_row[env_top], u, c);
          if (cv < h && env_top < MH) begin
            env_top++;
            env_row[env_top] = u;
            env_start[env_top] = cv;
          end
        end
      end
      for (int u = h-1; u >= 0; u--) begin
        sr = env_row[env_top];
        near_col[u*MW+c] = row_near[sr*MW+c][9:0];
        near_row[u*MW+c] = sr[7:0];
        if (u == env_start[env_top] && env_top > 0) env_top--;
      end
    end
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    if (idx == REG_WIDTH) width_reg = v;
    else if (idx == REG_HEIGHT) height_reg = v;
  endfunction

  function automatic void note(logic f, logic [7:0] x, logic [7:0] y, logic s, logic l);
    nearest_t e;
    if (f == FUNC_LOAD) begin
      loads++;
      pix_mem[int'(y)*MW + int'(x)] = s;
      if (l) transform();
    end else begin
      reads++;
      if (x < eff(width_reg, MW) && y < eff(height_reg, MH)) begin
        e.col = near_col[int'(y)*MW + int'(x)];
        e.row = near_row[int'(y)*MW + int'(x)];
      end else begin
        e = '0;
      end
      nearest_q.push_back(e);
    end
  endfunction

  function automatic void check(logic [OUT_COL_W-1:0] col, logic [OUT_ROW_W-1:0] row);
    nearest_t e;
    if (nearest_q.size() == 0) begin
      $error("unexpected result col=%0d row=%0d", col, row);
      errors++;
      return;
    end
    e = nearest_q.pop_front();
    if (col !== e.col) begin
      $error("nearest_col expected %0d actual %0d", e.col, col);
      errors++;
    end
    if (row !== e.row) begin
      $error("nearest_row expected %0d actual %0d", e.row, row);
      errors++;
    end
  endfunction

  function automatic int pending();
    return nearest_q.size();
  endfunction
endclass

module tb_euclidean_feature_transform_unit;
  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 start;
  logic                 busy;
  logic                 func;
  logic [PIX_W-1:0]     pixel_x;
  logic [PIX_W-1:0]     pixel_y;
  logic                 pixel_set;
  logic                 load_last;
  logic                 result_valid;
  logic [OUT_COL_W-1:0] nearest_col;
  logic [OUT_ROW_W-1:0] nearest_row;

  feature_scoreboard sb = new();
  bit no_idle;
  int items;

  euclidean_feature_transform_unit DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .func(func),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_set(pixel_set),
    .load_last(load_last), .result_valid(result_valid),
    .nearest_col(nearest_col), .nearest_row(nearest_row)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note(func, pixel_x, pixel_y, pixel_set, load_last);
      if (result_valid) sb.check(nearest_col, nearest_row);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send(logic f, logic [7:0] x, logic [7:0] y, logic s, logic l);
    int g;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start     <= 1'b1;
    func      <= f;
    pixel_x   <= x;
    pixel_y   <= y;
    pixel_set <= s;
    load_last <= l;
    do @(posedge clk); while (busy);
    items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // loads every pixel of the frame, the last one flagged, then reads nreads positions and position (255, 255) back
  task automatic run_frame(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv, int density,
                           int nreads);
    int w, h, n, k;
    logic s;
    logic [7:0] x, y;
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    no_idle = ($urandom_range(3) == 0);
    w = sb.eff(wv, 256);
    h = sb.eff(hv, 256);
    n = w*h;
    k = 0;
    for (int yy = 0; yy < h; yy++) begin
      for (int xx = 0; xx < w; xx++) begin
        k++;
        case (density)
          0: s = 1'b0;
          1: s = 1'b1;
          2: s = 1'($urandom_range(1));
          default: s = ($urandom_range(15) == 0);
        endcase
        // occasional load outside the image region
        if ($urandom_range(19) == 0 && w < 256)
          send(FUNC_LOAD, 8'($urandom_range(255, w)), 8'($urandom),
               1'($urandom_range(1)), 1'b0);
        send(FUNC_LOAD, 8'(xx), 8'(yy), s, k == n);
      end
    end
    for (int i = 0; i < nreads; i++) begin
      if ($urandom_range(9) == 0) begin
        x = 8'($urandom);
        y = 8'($urandom);
      end else begin
        x = 8'($urandom_range(w-1));
        y = 8'($urandom_range(h-1));
      end
      if ($urandom_range(24) == 0)
        send(FUNC_LOAD, 8'($urandom), 8'($urandom), 1'($urandom_range(1)), 1'b0);
      send(FUNC_READ, x, y, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    send(FUNC_READ, 8'hff, 8'hff, 1'b1, 1'b1);
    start <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    start = 1'b0;
    func = FUNC_LOAD;
    pixel_x = '0;
    pixel_y = '0;
    pixel_set = 1'b0;
    load_last = 1'b0;
    items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty, full and single-pixel frames, register extremes
    run_frame(9'd2, 9'd2, 0, 4);
    run_frame(9'd3, 9'd3, 1, 4);
    run_frame(9'd0, 9'd0, 1, 2);
    run_frame(9'd1, 9'd256, 3, 30);
    run_frame(9'd511, 9'd0, 3, 30);
    run_frame(9'd2, 9'd300, 2, 30);
    while (items < 1250) begin
      if ($urandom_range(9) == 0)
        run_frame(9'($urandom_range(40, 13)), 9'($urandom_range(20, 1)),
                  $urandom_range(3), $urandom_range(40, 10));
      else
        run_frame(9'($urandom_range(12, 1)), 9'($urandom_range(12, 1)),
                  $urandom_range(3), $urandom_range(40, 10));
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d frames: %0d loads and %0d reads checked",
             sb.frames, sb.loads, sb.reads);
    if (sb.errors == 0) begin
      $display("** euclidean_feature_transform_unit: PASSED **");
    end else begin
      $display("** euclidean_feature_transform_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout waiting for the block");
    $display("** euclidean_feature_transform_unit: FAILED **");
    $finish;
  end
endmodule
